/* design/armg_pkg.sv */
package armg_pkg;

  localparam int unsigned MaxBlock = 4096;
  localparam int unsigned PosW = $clog2(MaxBlock);

  localparam logic [30:0] InfBits = 31'h7F800000;
  localparam logic [30:0] OneBits = 31'h3F800000;
  localparam logic [23:0] RunCap = 24'hFFFFFF;
  localparam logic [12:0] ClipCap = 13'd8191;
  localparam logic [11:0] IndexCap = 12'd4095;

  localparam logic [30:0] MaxMagReset = 31'd1092616192;
  localparam logic [30:0] SusMagReset = 31'd1065353216;
  localparam logic [23:0] SusLimReset = 24'd480;

  typedef enum logic [0:0] {
    OpInspect = 1'b0,
    OpRearm   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KindNone    = 2'd0,
    KindNonFin  = 2'd1,
    KindRunaway = 2'd2
  } kind_e;

  localparam logic [1:0] AddrMaxMag = 2'd0;
  localparam logic [1:0] AddrSusMag = 2'd1;
  localparam logic [1:0] AddrSusLim = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] sample_in;
    logic        last_in_block;
  } in_t;

  typedef struct packed {
    logic [31:0] sample_out;
    logic        block_done;
    logic [1:0]  violation_kind;
    logic [11:0] violation_index;
    logic [30:0] peak_magnitude;
    logic [12:0] clipped_count;
    logic        muted_now;
  } out_t;

  typedef struct packed {
    logic [30:0] max_magnitude;
    logic [30:0] sustained_magnitude;
    logic [23:0] sustained_limit;
  } cfg_t;

endpackage

/* design/armg_stream_if.sv */
interface armg_in_if;
  import armg_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface armg_out_if;
  import armg_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/audio_runaway_mute_guard.sv */
// Runaway mute guard for a stream of IEEE single precision audio samples.
// Each input transfer carries an operation, a sample and an end-of-block
// mark; each input transfer yields exactly one output transfer carrying
// the sample (or zero while muted or on a rearm), the block status on the
// final inspected sample of a block, and the mute state after the item.
// A rearm operation clears the mute latch and the run count.
// The output is registered. One item is accepted every cycle while the
// receiver takes each result; the throughput is set by the single result
// register, which is refilled in the cycle it is emptied.
// When the receiver stalls, the result register holds and input ready
// falls until it is taken.
// Reset clears mute, counters and block status, and loads the register
// defaults (maximum 10.0, sustained level 1.0, limit 480 samples).
// The user must write configuration over the APB port only while the stream is idle; the block does not enforce it.
module audio_runaway_mute_guard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  armg_in_if.sink     in_if,
  armg_out_if.source  out_if
);
  import armg_pkg::*;

  cfg_t cfg;

  armg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  armg_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_if, .out_if
  );
endmodule

/* design/armg_regs.sv */
module armg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output armg_pkg::cfg_t     cfg_o
);
  import armg_pkg::*;

  cfg_t cfg_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_magnitude <= MaxMagReset;
      cfg_q.sustained_magnitude <= SusMagReset;
      cfg_q.sustained_limit <= SusLimReset;
    end else if (wr) begin
      case (paddr[3:2])
        AddrMaxMag: cfg_q.max_magnitude <= pwdata[30:0];
        AddrSusMag: cfg_q.sustained_magnitude <= pwdata[30:0];
        AddrSusLim: cfg_q.sustained_limit <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      AddrMaxMag: prdata = {1'b0, cfg_q.max_magnitude};
      AddrSusMag: prdata = {1'b0, cfg_q.sustained_magnitude};
      AddrSusLim: prdata = {8'd0, cfg_q.sustained_limit};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

/* design/armg_core.sv */
module armg_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  armg_pkg::cfg_t cfg_i,
  armg_in_if.sink        in_if,
  armg_out_if.source     out_if
);
  import armg_pkg::*;

  logic        mute_q, mute_d;
  logic [23:0] run_q, run_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [30:0] peak_q, peak_d;
  logic [12:0] clips_q, clips_d;
  logic [1:0]  viol_q, viol_d;
  logic [11:0] viol_at_q, viol_at_d;
  logic        ovalid_q;
  out_t        odata_q, odata_d;
  logic        take;

  logic [30:0] mag, level;
  logic [23:0] limit, run_inc;
  logic        finite;
  kind_e       kind;

  assign in_if.ready = !ovalid_q || out_if.ready;
  assign take = in_if.valid && in_if.ready;

  assign mag = in_if.data.sample_in[30:0];
  assign finite = mag < InfBits;
  assign level = (cfg_i.sustained_magnitude < cfg_i.max_magnitude) ?
                 cfg_i.sustained_magnitude : cfg_i.max_magnitude;
  assign limit = (cfg_i.sustained_limit == 24'd0) ? 24'd1 : cfg_i.sustained_limit;
  assign run_inc = (run_q < RunCap) ? run_q + 24'd1 : run_q;

  always_comb begin
    mute_d = mute_q;
    run_d = run_q;
    pos_d = pos_q;
    peak_d = peak_q;
    clips_d = clips_q;
    viol_d = viol_q;
    viol_at_d = viol_at_q;
    odata_d = '0;
    kind = KindNone;
    if (in_if.data.operation == OpRearm) begin
      mute_d = 1'b0;
      run_d = '0;
    end else begin
      if (!mute_q) begin
        if (finite) begin
          if (mag > peak_q) peak_d = mag;
          if (mag > OneBits && clips_q < ClipCap) clips_d = clips_q + 13'd1;
        end
        if (!finite) begin
          kind = KindNonFin;
        end else if (mag > cfg_i.max_magnitude) begin
          kind = KindRunaway;
        end else begin
          run_d = (mag > level) ? run_inc : 24'd0;
          if (run_d >= limit) kind = KindRunaway;
        end
        if (kind != KindNone) begin
          mute_d = 1'b1;
          viol_d = kind;
          viol_at_d = (12'(pos_q) < IndexCap) ? 12'(pos_q) : IndexCap;
        end else begin
          odata_d.sample_out = in_if.data.sample_in;
        end
      end
      if (in_if.data.last_in_block) begin
        odata_d.block_done = 1'b1;
        odata_d.violation_kind = viol_d;
        odata_d.violation_index = viol_at_d;
        odata_d.peak_magnitude = peak_d;
        odata_d.clipped_count = clips_d;
        pos_d = '0;
        peak_d = '0;
        clips_d = '0;
        viol_d = '0;
        viol_at_d = '0;
      end else if (pos_q < PosW'(MaxBlock - 1)) begin
        pos_d = pos_q + 1'b1;
      end
    end
    odata_d.muted_now = mute_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mute_q <= 1'b0;
      run_q <= '0;
      pos_q <= '0;
      peak_q <= '0;
      clips_q <= '0;
      viol_q <= '0;
      viol_at_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        mute_q <= mute_d;
        run_q <= run_d;
        pos_q <= pos_d;
        peak_q <= peak_d;
        clips_q <= clips_d;
        viol_q <= viol_d;
        viol_at_q <= viol_at_d;
        ovalid_q <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) odata_q <= odata_d;
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data = odata_q;

`ifndef SYNTHESIS
  a_muted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && odata_q.muted_now |-> odata_q.sample_out == 32'd0)
    else $error("sample passed while muted");
  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !odata_q.block_done |-> odata_q.violation_kind == KindNone &&
    odata_q.clipped_count == 13'd0 && odata_q.peak_magnitude == 31'd0)
    else $error("status outside block end");
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ovalid_q |-> in_if.ready)
    else $error("input blocked while result register empty");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_if.ready |=> ovalid_q)
    else $error("result lost under stall");
`endif
endmodule

/* tb/armg_guard_model.sv */
`timescale 1ns / 1ps
package armg_guard_model;
  import armg_pkg::*;

  class guard_scoreboard;
    logic [30:0] max_mag;
    logic [30:0] sus_mag;
    logic [23:0] sus_lim;
    bit          muted;
    logic [23:0] run_len;
    logic [12:0] pos;
    logic [30:0] peak;
    logic [12:0] clips;
    logic [1:0]  viol;
    logic [11:0] viol_at;
    out_t        pending[$];
    int          mismatches;
    int          results_seen;

    function new();
      max_mag = MaxMagReset;
      sus_mag = SusMagReset;
      sus_lim = SusLimReset;
      muted = 0;
      run_len = '0;
      pos = '0;
      peak = '0;
      clips = '0;
      viol = KindNone;
      viol_at = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [31:0] value);
      case (addr)
        AddrMaxMag: max_mag = value[30:0];
        AddrSusMag: sus_mag = value[30:0];
        AddrSusLim: sus_lim = value[23:0];
        default: ;
      endcase
    endfunction

    function void note_input(in_t item);
      out_t        res;
      logic [30:0] mag;
      logic [30:0] level;
      logic [23:0] lim;
      logic [1:0]  kind;
      res = '0;
      if (item.operation == OpRearm) begin
        muted = 0;
        run_len = '0;
        pending.push_back(res);
        return;
      end
      if (!muted) begin
        mag = item.sample_in[30:0];
        level = (sus_mag < max_mag) ? sus_mag : max_mag;
        lim = (sus_lim == 0) ? 24'd1 : sus_lim;
        kind = KindNone;
        if (mag < InfBits) begin
          if (mag > peak) peak = mag;
          if (mag > OneBits && clips < ClipCap) clips++;
          if (mag > max_mag) begin
            kind = KindRunaway;
          end else begin
            if (mag > level) begin
              if (run_len < RunCap) run_len++;
            end else begin
              run_len = '0;
            end
            if (run_len >= lim) kind = KindRunaway;
          end
        end else begin
          kind = KindNonFin;
        end
        if (kind != KindNone) begin
          muted = 1;
          viol = kind;
          viol_at = (pos < IndexCap) ? pos[11:0] : IndexCap;
        end else begin
          res.sample_out = item.sample_in;
        end
      end
      if (item.last_in_block) begin
        res.block_done = 1;
        res.violation_kind = viol;
        res.violation_index = viol_at;
        res.peak_magnitude = peak;
        res.clipped_count = clips;
        pos = '0;
        peak = '0;
        clips = '0;
        viol = KindNone;
        viol_at = '0;
      end else if (pos < MaxBlock - 1) begin
        pos++;
      end
      res.muted_now = muted;
      pending.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass
endpackage

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import armg_pkg::*;
  import armg_guard_model::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          calm;

  armg_in_if  in_ch ();
  armg_out_if out_ch ();

  guard_scoreboard board;

  audio_runaway_mute_guard uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("audio_runaway_mute_guard test failed");
    $finish;
  end

  task automatic write_reg(logic [1:0] addr, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {addr, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.set_reg(addr, value);
  endtask

  task automatic send_item(in_t item);
    while (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.data <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_input(item);
  endtask

  task automatic go_idle();
    in_ch.valid <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_t make_item(logic op, logic [31:0] s, logic last);
    in_t it;
    it.operation = op;
    it.sample_in = s;
    it.last_in_block = last;
    return it;
  endfunction

  function automatic logic [31:0] rand_sample();
    logic [31:0] s;
    s = $urandom();
    case ($urandom_range(7))
      0: s[30:0] = 31'h7F800000;
      1: s[30:0] = 31'h7F800000 | 31'($urandom() & 32'h7FFFFF);
      2: s[30:0] = 31'h3F800000 + 31'($urandom_range(4));
      3: s[30:0] = 31'h3F000000 + 31'($urandom() & 32'hFFFFFF);
      4: s[30:0] = 31'h3F800000 + 31'($urandom() & 32'h1FFFFFF);
      5: s[30:0] = 31'h41200000 + 31'($urandom_range(2)) - 31'd1;
      default: ;
    endcase
    return s;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
  end

  initial begin
    int n;
    int len;
    int phase;
    board = new();
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    calm = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_item(make_item(OpInspect, 32'h3F800000, 0));
    send_item(make_item(OpInspect, 32'hBF800001, 0));
    send_item(make_item(OpInspect, 32'h41200000, 0));
    send_item(make_item(OpInspect, 32'h00000000, 1));
    send_item(make_item(OpInspect, 32'hC1200001, 0));
    send_item(make_item(OpInspect, 32'h12345678, 1));
    send_item(make_item(OpInspect, 32'h3F000000, 1));
    send_item(make_item(OpRearm, 32'hFFFFFFFF, 1));
    send_item(make_item(OpInspect, 32'h7F800000, 0));
    send_item(make_item(OpRearm, 32'h0, 0));
    send_item(make_item(OpInspect, 32'hFFC00001, 1));
    send_item(make_item(OpRearm, 32'h0, 0));
    send_item(make_item(OpInspect, 32'h80000000, 1));
    go_idle();

    write_reg(AddrSusLim, 32'd0);
    write_reg(AddrMaxMag, 32'h7FFFFFFF);
    write_reg(AddrSusMag, 32'h0);
    send_item(make_item(OpInspect, 32'h00000001, 0));
    send_item(make_item(OpInspect, 32'hFF7FFFFF, 1));
    send_item(make_item(OpRearm, 32'h0, 0));
    send_item(make_item(OpInspect, 32'h7F7FFFFF, 1));
    go_idle();

    n = 0;
    phase = 0;
    while (n < 800) begin
      if (n >= phase * 200) begin
        go_idle();
        case (phase % 4)
          0: begin
            write_reg(AddrMaxMag, 32'h41200000);
            write_reg(AddrSusMag, 32'h3F800000);
            write_reg(AddrSusLim, $urandom_range(1, 6));
          end
          1: begin
            write_reg(AddrMaxMag, $urandom());
            write_reg(AddrSusMag, $urandom());
            write_reg(AddrSusLim, $urandom_range(1, 12));
          end
          2: begin
            write_reg(AddrMaxMag, 32'h0);
            write_reg(AddrSusMag, 32'h7FFFFFFF);
            write_reg(AddrSusLim, 32'hFFFFFF);
          end
          default: begin
            write_reg(AddrMaxMag, 32'h7F7FFFFF);
            write_reg(AddrSusMag, 32'h3F800000);
            write_reg(AddrSusLim, $urandom_range(2, 30));
          end
        endcase
        calm = (phase == 2);
        phase++;
      end
      len = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(19) == 0)
          send_item(make_item(OpRearm, $urandom(), 1'($urandom_range(1))));
        else
          send_item(make_item(OpInspect, rand_sample(), k == len - 1));
        n++;
      end
    end

    go_idle();
    write_reg(AddrMaxMag, 32'h7F7FFFFF);
    write_reg(AddrSusMag, 32'h7F7FFFFF);
    write_reg(AddrSusLim, 32'd16);
    calm = 1;
    for (int k = 0; k < 200; k++)
      send_item(make_item(OpInspect, 32'h3F800001, k == 199));
    in_ch.valid <= 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results over directed cases, several register settings,",
             board.results_seen);
    $display("random blocks with rearms and one long block of clipped samples.");
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("audio_runaway_mute_guard test passed");
    else
      $display("audio_runaway_mute_guard test failed");
    $finish;
  end
endmodule
